>>> hw/rtl/mrcr_pkg.sv
// Shared constants, codes and types of the mesh relay and chunk reassembly block.
package mrcr_pkg;

   localparam int STORE_BYTES_DEF   = 1024;
   localparam int MAX_CHUNKS_DEF    = 256;
   localparam int CACHE_ENTRIES_DEF = 3;

   // Store addresses are carried at the widest legal store size.
   localparam int STORE_AW_MAX = 16;
   // Offset arithmetic width: index * size + position fits in 17 bits.
   localparam int OFS_W = 17;

   localparam logic [7:0] UPDATE_MARK = 8'h99;
   localparam logic [7:0] RELAY_LEN   = 8'd16;
   localparam logic [7:0] HOP_POS     = 8'd11;
   localparam logic [7:0] HEADER_LEN  = 8'd3;
   localparam logic [7:0] BAD_LEN     = 8'd255;
   localparam logic [7:0] POS_MAX     = 8'd255;

   typedef enum logic [2:0] {
      VERDICT_IGNORED   = 3'd0,
      VERDICT_HOP_EXP   = 3'd1,
      VERDICT_OWN_ECHO  = 3'd2,
      VERDICT_DUPLICATE = 3'd3,
      VERDICT_RELAY     = 3'd4,
      VERDICT_REJECTED  = 3'd5,
      VERDICT_ACCEPTED  = 3'd6,
      VERDICT_COMPLETE  = 3'd7
   } verdict_type;

   typedef struct packed {
      logic                    we;
      logic [STORE_AW_MAX-1:0] waddr;
      logic [7:0]              wdata;
      logic                    re;
      logic [STORE_AW_MAX-1:0] raddr;
   } store_cmd_type;

   typedef struct packed {
      verdict_type verdict;
      logic [7:0]  hop;
      logic [31:0] id;
      logic [10:0] assembled;
      logic        rd_sel;
   } res_type;

endpackage

>>> hw/rtl/mrcr_if.sv
// Channel interfaces: request, response and configuration write.
interface mrcr_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] rx_byte;
   logic [7:0] packet_length;
   logic       last_byte;
   logic [9:0] read_address;

   modport source (output valid, cmd, rx_byte, packet_length, last_byte, read_address,
                   input ready);
   modport sink   (input valid, cmd, rx_byte, packet_length, last_byte, read_address,
                   output ready);
endinterface

interface mrcr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  verdict;
   logic [7:0]  relay_hop_count;
   logic [31:0] sender_id;
   logic [10:0] assembled_bytes;
   logic [7:0]  read_data;

   modport source (output valid, verdict, relay_hop_count, sender_id, assembled_bytes,
                   read_data, input ready);
   modport sink   (input valid, verdict, relay_hop_count, sender_id, assembled_bytes,
                   read_data, output ready);
endinterface

interface mrcr_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

>>> hw/rtl/mrcr_store.sv
// Reassembly byte store: one write port, one registered read port.
module mrcr_store #(
   parameter int STORE_BYTES = mrcr_pkg::STORE_BYTES_DEF
) (
   input  logic                    clock,
   input  mrcr_pkg::store_cmd_type cmd,
   output logic [7:0]              rdata
);
   localparam int AW = $clog2(STORE_BYTES);

   logic [7:0] mem_ff [STORE_BYTES];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem_ff[cmd.waddr[AW-1:0]] <= cmd.wdata;
      end
      if (cmd.re) begin
         rdata_ff <= mem_ff[cmd.raddr[AW-1:0]];
      end
   end

   assign rdata = rdata_ff;
endmodule

>>> hw/rtl/mrcr_core.sv
// Packet parser: header capture, chunk checks, relay filter, counters and store control.
module mrcr_core #(
   parameter int STORE_BYTES   = mrcr_pkg::STORE_BYTES_DEF,
   parameter int MAX_CHUNKS    = mrcr_pkg::MAX_CHUNKS_DEF,
   parameter int CACHE_ENTRIES = mrcr_pkg::CACHE_ENTRIES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   mrcr_req_if.sink                req,
   mrcr_csr_if.sink                csr,
   input  logic                    in_ready,
   output mrcr_pkg::store_cmd_type store_cmd,
   output logic                    res_valid,
   output mrcr_pkg::res_type       res
);
   localparam int IW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam logic [mrcr_pkg::OFS_W-1:0] STORE_LIM = mrcr_pkg::OFS_W'(STORE_BYTES);
   localparam logic [8:0] CHUNK_LIM = 9'(MAX_CHUNKS);

   logic [7:0]            pos_ff,    pos_in;
   logic [31:0]           hid_ff,    hid_in;
   logic [7:0]            cidx_ff,   cidx_in;
   logic [7:0]            total_ff,  total_in;
   logic [7:0]            hop_ff,    hop_in;
   logic                  upd_ff,    upd_in;
   logic                  acc_ff,    acc_in;
   logic [MAX_CHUNKS-1:0] seen_ff,   seen_in;
   logic [7:0]            chunks_ff, chunks_in;
   logic [10:0]           bytes_ff,  bytes_in;
   logic [31:0]           cache_ff [CACHE_ENTRIES];
   logic [31:0]           cache_in [CACHE_ENTRIES];
   logic [31:0]           own_ff,    own_in;
   logic                  s1_valid_ff, s1_valid_in;
   mrcr_pkg::res_type     s1_res_ff,   s1_res_in;

   logic        accept;
   logic [7:0]  b, len;
   logic        first;
   logic        upd_n, acc_mid;
   logic [31:0] hid_n;
   logic [7:0]  hop_n, cidx_n, total_n;
   logic [7:0]  size, p;
   logic [15:0] prod;
   logic [mrcr_pkg::OFS_W-1:0] chunk_end, wr_addr, rd_addr;
   logic        len_ok, hdr_chk, cache_hit;
   logic [11:0] bytes_sum;
   logic [7:0]  chunks_new;

   assign accept = req.valid & req.ready;
   assign req.ready = in_ready;
   assign csr.ready = 1'b1;

   assign b     = req.rx_byte;
   assign len   = req.packet_length;
   assign first = (pos_ff == 8'd0);

   // Header fields as they stand after this byte.
   assign upd_n   = first ? (b == mrcr_pkg::UPDATE_MARK) : upd_ff;
   assign hid_n   = (pos_ff < 8'd4) ? {(first ? 24'd0 : hid_ff[23:0]), b} : hid_ff;
   assign hop_n   = (pos_ff == mrcr_pkg::HOP_POS) ? b : (first ? 8'd0 : hop_ff);
   assign cidx_n  = (pos_ff == 8'd1) ? b : cidx_ff;
   assign hdr_chk = (pos_ff == 8'd2) && upd_n;
   assign total_n = hdr_chk ? b : total_ff;

   // One multiplier serves both the fit check and the byte address.
   assign len_ok    = (len >= mrcr_pkg::HEADER_LEN);
   assign size      = len - mrcr_pkg::HEADER_LEN;
   assign p         = pos_ff - mrcr_pkg::HEADER_LEN;
   assign prod      = 16'(cidx_n) * 16'(size);
   assign chunk_end = mrcr_pkg::OFS_W'(prod) + mrcr_pkg::OFS_W'(size);
   assign wr_addr   = mrcr_pkg::OFS_W'(prod) + mrcr_pkg::OFS_W'(p);
   assign rd_addr   = mrcr_pkg::OFS_W'(req.read_address);

   assign acc_mid = (first ? 1'b0 : acc_ff) |
                    (hdr_chk && len_ok && (len != mrcr_pkg::BAD_LEN) &&
                     ({1'b0, cidx_n} < CHUNK_LIM) && !seen_ff[cidx_n[IW-1:0]] &&
                     (chunk_end <= STORE_LIM));

   always_comb begin
      cache_hit = 1'b0;
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
         cache_hit = cache_hit | (cache_ff[i] == hid_n);
      end
   end

   assign bytes_sum  = 12'(bytes_ff) + 12'(size);
   assign chunks_new = (chunks_ff == 8'hFF) ? chunks_ff : chunks_ff + 8'd1;

   always_comb begin
      pos_in      = pos_ff;
      hid_in      = hid_ff;
      cidx_in     = cidx_ff;
      total_in    = total_ff;
      hop_in      = hop_ff;
      upd_in      = upd_ff;
      acc_in      = acc_ff;
      seen_in     = seen_ff;
      chunks_in   = chunks_ff;
      bytes_in    = bytes_ff;
      cache_in    = cache_ff;
      own_in      = csr.valid ? csr.data : own_ff;
      store_cmd   = '0;
      s1_valid_in = 1'b0;
      s1_res_in   = '0;

      if (accept && req.cmd) begin
         // Read: packet state stays untouched.
         store_cmd.re        = 1'b1;
         store_cmd.raddr     = rd_addr[mrcr_pkg::STORE_AW_MAX-1:0];
         s1_valid_in         = 1'b1;
         s1_res_in.verdict   = mrcr_pkg::VERDICT_IGNORED;
         s1_res_in.assembled = bytes_ff;
         s1_res_in.rd_sel    = (rd_addr < STORE_LIM);
      end else if (accept) begin
         upd_in   = upd_n;
         acc_in   = acc_mid;
         hid_in   = hid_n;
         hop_in   = hop_n;
         cidx_in  = cidx_n;
         total_in = total_n;

         // Store payload bytes of an accepted chunk.
         if ((pos_ff >= mrcr_pkg::HEADER_LEN) && acc_mid && len_ok && (p < size) &&
             (wr_addr < STORE_LIM)) begin
            store_cmd.we    = 1'b1;
            store_cmd.waddr = wr_addr[mrcr_pkg::STORE_AW_MAX-1:0];
            store_cmd.wdata = b;
         end

         if (!req.last_byte) begin
            pos_in = (pos_ff == mrcr_pkg::POS_MAX) ? pos_ff : pos_ff + 8'd1;
         end else begin
            pos_in            = 8'd0;
            s1_valid_in       = 1'b1;
            s1_res_in.verdict = mrcr_pkg::VERDICT_IGNORED;
            if ((len == 8'd0) || (len == mrcr_pkg::BAD_LEN)) begin
               s1_res_in.verdict = mrcr_pkg::VERDICT_IGNORED;
            end else if (upd_n) begin
               acc_in = 1'b0;
               if (acc_mid && len_ok && (pos_ff == len - 8'd1)) begin
                  seen_in[cidx_n[IW-1:0]] = 1'b1;
                  chunks_in = chunks_new;
                  bytes_in  = bytes_sum[11] ? 11'h7FF : bytes_sum[10:0];
                  s1_res_in.verdict = (chunks_new >= total_n) ?
                                      mrcr_pkg::VERDICT_COMPLETE :
                                      mrcr_pkg::VERDICT_ACCEPTED;
               end else begin
                  s1_res_in.verdict = mrcr_pkg::VERDICT_REJECTED;
               end
            end else if ((len == mrcr_pkg::RELAY_LEN) &&
                         (pos_ff == mrcr_pkg::RELAY_LEN - 8'd1)) begin
               s1_res_in.id = hid_n;
               if (hop_n == 8'd0) begin
                  s1_res_in.verdict = mrcr_pkg::VERDICT_HOP_EXP;
               end else if (hid_n == own_ff) begin
                  s1_res_in.verdict = mrcr_pkg::VERDICT_OWN_ECHO;
               end else if (cache_hit) begin
                  s1_res_in.verdict = mrcr_pkg::VERDICT_DUPLICATE;
               end else begin
                  // Relay: push id into the recent-sender cache, oldest drops out.
                  s1_res_in.verdict = mrcr_pkg::VERDICT_RELAY;
                  s1_res_in.hop     = hop_n - 8'd1;
                  for (int i = 1; i < CACHE_ENTRIES; i++) begin
                     cache_in[i] = cache_ff[i-1];
                  end
                  cache_in[0] = hid_n;
               end
            end
            s1_res_in.assembled = bytes_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         hid_ff      <= '0;
         cidx_ff     <= '0;
         total_ff    <= '0;
         hop_ff      <= '0;
         upd_ff      <= 1'b0;
         acc_ff      <= 1'b0;
         seen_ff     <= '0;
         chunks_ff   <= '0;
         bytes_ff    <= '0;
         own_ff      <= '0;
         s1_valid_ff <= 1'b0;
         for (int i = 0; i < CACHE_ENTRIES; i++) begin
            cache_ff[i] <= '0;
         end
      end else begin
         pos_ff      <= pos_in;
         hid_ff      <= hid_in;
         cidx_ff     <= cidx_in;
         total_ff    <= total_in;
         hop_ff      <= hop_in;
         upd_ff      <= upd_in;
         acc_ff      <= acc_in;
         seen_ff     <= seen_in;
         chunks_ff   <= chunks_in;
         bytes_ff    <= bytes_in;
         own_ff      <= own_in;
         s1_valid_ff <= s1_valid_in;
         cache_ff    <= cache_in;
      end
      s1_res_ff <= s1_res_in;
   end

   assign res_valid = s1_valid_ff;
   assign res       = s1_res_ff;
endmodule

>>> hw/rtl/mrcr_out_fifo.sv
// Two-entry response queue; merges store read data and drives request flow control.
module mrcr_out_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mrcr_pkg::res_type push_res,
   input  logic [7:0]        push_rdata,
   output logic              in_ready,
   mrcr_rsp_if.source        rsp
);
   logic [1:0]        cnt_ff, cnt_in;
   logic              wptr_ff, wptr_in;
   logic              rptr_ff, rptr_in;
   mrcr_pkg::res_type res_ff  [2];
   logic [7:0]        byte_ff [2];
   logic              pop;
   logic [2:0]        occ;

   assign pop = rsp.valid & rsp.ready;
   // Take a request only if the stage ahead of the queue can still drain into it.
   assign occ      = 3'(cnt_ff) + 3'(push) - 3'(pop);
   assign in_ready = (occ <= 3'd1);

   always_comb begin
      cnt_in  = 2'(3'(cnt_ff) + 3'(push) - 3'(pop));
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop  ? ~rptr_ff : rptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
      end
      if (push) begin
         res_ff[wptr_ff]  <= push_res;
         byte_ff[wptr_ff] <= push_res.rd_sel ? push_rdata : 8'd0;
      end
   end

   assign rsp.valid           = (cnt_ff != 2'd0);
   assign rsp.verdict         = res_ff[rptr_ff].verdict;
   assign rsp.relay_hop_count = res_ff[rptr_ff].hop;
   assign rsp.sender_id       = res_ff[rptr_ff].id;
   assign rsp.assembled_bytes = res_ff[rptr_ff].assembled;
   assign rsp.read_data       = byte_ff[rptr_ff];
endmodule

>>> hw/rtl/mesh_relay_and_chunk_reassembly.sv
// A response passes the parser result register and then a queue entry before it is presented.
// One request per cycle while the queue has room; parser, store and queue each take one.
// Packet bytes without the last-byte mark give no response; reads and last bytes give one.
// Reset is synchronous: it clears position, header, counters, seen map, sender cache and
// node id. The byte store is not cleared and needs no clearing pass.
module mesh_relay_and_chunk_reassembly #(
   parameter int STORE_BYTES   = mrcr_pkg::STORE_BYTES_DEF,
   parameter int MAX_CHUNKS    = mrcr_pkg::MAX_CHUNKS_DEF,
   parameter int CACHE_ENTRIES = mrcr_pkg::CACHE_ENTRIES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mrcr_req_if.sink   req_chan,
   mrcr_rsp_if.source rsp_chan,
   mrcr_csr_if.sink   csr_chan
);
   // Parser to store: write one payload byte or read one byte per request.
   mrcr_pkg::store_cmd_type store_cmd;
   logic [7:0]              store_rdata;
   // Parser result stage; the store read data lines up with it in the same cycle.
   logic                    res_valid;
   mrcr_pkg::res_type       res;
   // Queue room, handed back to the request channel.
   logic                    in_ready;

   // Header capture, chunk acceptance, relay filter, counters.
   mrcr_core #(
      .STORE_BYTES   (STORE_BYTES),
      .MAX_CHUNKS    (MAX_CHUNKS),
      .CACHE_ENTRIES (CACHE_ENTRIES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .csr       (csr_chan),
      .in_ready  (in_ready),
      .store_cmd (store_cmd),
      .res_valid (res_valid),
      .res       (res)
   );

   // Reassembly memory with registered read data.
   mrcr_store #(
      .STORE_BYTES (STORE_BYTES)
   ) u_store (
      .clock (clock),
      .cmd   (store_cmd),
      .rdata (store_rdata)
   );

   // Hold responses while the consumer stalls; keep taking requests while room remains.
   mrcr_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_res   (res),
      .push_rdata (store_rdata),
      .in_ready   (in_ready),
      .rsp        (rsp_chan)
   );
endmodule
